@@ hdl/mrfe_pkg.sv @@
// shared types, constants and crc function for the modbus rtu frame engine
package mrfe_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 256;
  localparam int unsigned HEAD_BYTES      = 6;
  localparam int unsigned MAX_RESULTS     = 3;
  localparam int unsigned CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned HEAD_IDX_W      = $clog2(HEAD_BYTES);
  localparam int unsigned RES_CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned RES_IDX_W       = $clog2(MAX_RESULTS);
  localparam int unsigned IN_TDATA_W      = 24;
  localparam int unsigned OUT_TDATA_W     = 16;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;

  typedef enum logic {
    OP_REQUEST  = 1'b0,
    OP_RESPONSE = 1'b1
  } opcode_e;

  typedef enum logic {
    KIND_TX      = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_LENGTH  = 2'd1,
    VERDICT_ECHO    = 2'd2,
    VERDICT_CRC     = 2'd3
  } verdict_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] tx_byte;
    logic       run_end;
    verdict_e   verdict;
  } res_t;

  typedef struct packed {
    logic                 load;
    logic [RES_CNT_W-1:0] count;
  } res_load_t;

  function automatic logic [15:0] mrfe_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/mrfe_res_buf.sv @@
// result register holding up to three results of one input byte, drained one per cycle while the output is ready
module mrfe_res_buf (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  mrfe_pkg::res_load_t                    ld_i,
  input  mrfe_pkg::res_t [mrfe_pkg::MAX_RESULTS-1:0] res_i,
  output logic                                   free_o,
  output logic                                   tvalid_o,
  input  logic                                   tready_i,
  output mrfe_pkg::res_t                         res_o
);
  import mrfe_pkg::*;

  res_t                 res_q [MAX_RESULTS];
  logic [RES_IDX_W-1:0] rd_q, rd_d;
  logic [RES_CNT_W-1:0] rem_q, rem_d;
  logic                 pop;

  assign tvalid_o = (rem_q != '0);
  assign pop      = tvalid_o && tready_i;
  assign free_o   = (rem_q == '0) || ((rem_q == RES_CNT_W'(1)) && pop);
  assign res_o    = res_q[rd_q];

  always_comb begin
    rd_d  = rd_q;
    rem_d = rem_q;
    if (ld_i.load) begin
      rd_d  = '0;
      rem_d = ld_i.count;
    end else if (pop) begin
      rd_d  = rd_q + RES_IDX_W'(1);
      rem_d = rem_q - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      rem_q <= '0;
    end else begin
      rd_q  <= rd_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        res_q[i] <= res_i[i];
      end
    end
  end

endmodule

@@ hdl/modbus_rtu_frame_engine_unit.sv @@
// modbus rtu master frame engine: request crc append and response length, echo and crc check
//
// Request bytes (tuser 0) pass straight to the output while a CRC-16 (init 0xFFFF, reflected
// poly 0xA001) runs over them; the byte marked tlast is followed by the CRC low and high byte,
// the high byte carrying tlast. Response bytes (tuser 1) produce nothing until the tlast byte,
// which produces one verdict result (tuser 1, tlast 1). A new byte is accepted every cycle while
// the result register can take the byte already held; each byte passes through the one-item input
// register into the three-entry result register, which drains one result per cycle while the
// output is ready: after a request byte marked tlast the input holds off while the CRC bytes
// go out, and any output stall holds the input once the one-item input register is full.
module modbus_rtu_frame_engine_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mrfe_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // data_byte[7:0], expected_length[16:8]
  input  logic                            s_axis_tlast,  // frame_end
  input  logic                            s_axis_tuser,  // opcode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mrfe_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // tx_byte[7:0], verdict[9:8]
  output logic                            m_axis_tlast,  // run_end
  output logic                            m_axis_tuser   // result_kind
);
  import mrfe_pkg::*;

  logic             in_vld_q;
  opcode_e          in_op_q;
  logic [7:0]       in_byte_q;
  logic             in_last_q;
  logic [CNT_W-1:0] in_exp_q;

  logic [15:0]           crc_q, crc_d;
  logic [7:0]            head_q [HEAD_BYTES];
  logic [HEAD_IDX_W-1:0] head_cnt_q, head_cnt_d;
  logic [7:0]            fc_q, fc_d;
  logic [CNT_W-1:0]      resp_cnt_q, resp_cnt_d;
  logic                  echo_bad_q, echo_bad_d;

  logic        accept, move, res_free, head_wr;
  logic [15:0] crc_nxt;
  logic [CNT_W-1:0] cnt_inc;
  logic        resp_in_head, echo_now;
  verdict_e    verdict;
  res_load_t   ld;
  res_t [MAX_RESULTS-1:0] res;
  res_t        res_out;

  assign move          = in_vld_q && res_free;
  assign s_axis_tready = !in_vld_q || move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q   <= opcode_e'(s_axis_tuser);
      in_byte_q <= s_axis_tdata[7:0];
      in_last_q <= s_axis_tlast;
      in_exp_q  <= s_axis_tdata[8 +: CNT_W];
    end
  end

  assign crc_nxt      = mrfe_crc_byte(crc_q, in_byte_q);
  assign resp_in_head = (resp_cnt_q < CNT_W'(HEAD_BYTES));
  assign echo_now     = echo_bad_q ||
                        (resp_in_head && (head_q[resp_cnt_q[HEAD_IDX_W-1:0]] != in_byte_q));
  assign cnt_inc      = (resp_cnt_q < CNT_W'(MAX_FRAME_BYTES)) ? resp_cnt_q + CNT_W'(1)
                                                                : resp_cnt_q;
  assign head_wr      = move && (in_op_q == OP_REQUEST) &&
                        (head_cnt_q < HEAD_IDX_W'(HEAD_BYTES));

  always_comb begin
    verdict = VERDICT_OK;
    if (cnt_inc != in_exp_q) begin
      verdict = VERDICT_LENGTH;
    end else if ((fc_q == FC_WRITE_SINGLE) || (fc_q == FC_WRITE_MULTI)) begin
      if (echo_now || (cnt_inc < CNT_W'(HEAD_BYTES))) begin
        verdict = VERDICT_ECHO;
      end
    end else if (fc_q == FC_READ_HOLDING) begin
      if (crc_nxt != 16'h0000) begin
        verdict = VERDICT_CRC;
      end
    end
  end

  always_comb begin
    crc_d      = crc_q;
    head_cnt_d = head_cnt_q;
    fc_d       = fc_q;
    resp_cnt_d = resp_cnt_q;
    echo_bad_d = echo_bad_q;
    ld.load    = move;
    ld.count   = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '{kind: KIND_TX, tx_byte: 8'h00, run_end: 1'b0, verdict: VERDICT_OK};
    end
    if (move) begin
      crc_d = crc_nxt;
      unique case (in_op_q)
        OP_REQUEST: begin
          if (head_cnt_q < HEAD_IDX_W'(HEAD_BYTES)) begin
            head_cnt_d = head_cnt_q + HEAD_IDX_W'(1);
            if (head_cnt_q == HEAD_IDX_W'(1)) begin
              fc_d = in_byte_q;
            end
          end
          res[0].tx_byte = in_byte_q;
          ld.count       = RES_CNT_W'(1);
          if (in_last_q) begin
            res[1].tx_byte = crc_nxt[7:0];
            res[2].tx_byte = crc_nxt[15:8];
            res[2].run_end = 1'b1;
            ld.count       = RES_CNT_W'(MAX_RESULTS);
            crc_d          = CRC_INIT;
            head_cnt_d     = '0;
            resp_cnt_d     = '0;
            echo_bad_d     = 1'b0;
          end
        end
        OP_RESPONSE: begin
          resp_cnt_d = cnt_inc;
          echo_bad_d = echo_now;
          if (in_last_q) begin
            res[0].kind    = KIND_VERDICT;
            res[0].run_end = 1'b1;
            res[0].verdict = verdict;
            ld.count       = RES_CNT_W'(1);
            crc_d          = CRC_INIT;
            resp_cnt_d     = '0;
            echo_bad_d     = 1'b0;
          end
        end
        default: begin
          crc_d = crc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CRC_INIT;
      head_cnt_q <= '0;
      fc_q       <= '0;
      resp_cnt_q <= '0;
      echo_bad_q <= 1'b0;
    end else begin
      crc_q      <= crc_d;
      head_cnt_q <= head_cnt_d;
      fc_q       <= fc_d;
      resp_cnt_q <= resp_cnt_d;
      echo_bad_q <= echo_bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_wr) begin
      head_q[head_cnt_q] <= in_byte_q;
    end
  end

  mrfe_res_buf u_res_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ld_i     (ld),
    .res_i    (res),
    .free_o   (res_free),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .res_o    (res_out)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - 10){1'b0}}, res_out.verdict, res_out.tx_byte};
  assign m_axis_tlast = res_out.run_end;
  assign m_axis_tuser = res_out.kind;

endmodule

@@ hdl/mrfe_checker.sv @@
// port-level checks for the frame engine and the bind that attaches them
module mrfe_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mrfe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic                             m_axis_tuser
);
  import mrfe_pkg::*;

  // a verdict always closes its run
  a_verdict_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_VERDICT)) |-> m_axis_tlast)
    else $error("verdict without tlast");

  // transmit results carry no verdict code
  a_tx_no_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_TX)) |-> (m_axis_tdata[9:8] == 2'd0))
    else $error("transmit result with verdict bits");

  // verdict results carry no transmit byte
  a_verdict_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_VERDICT)) |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("verdict with transmit byte");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // input is always open while no result is waiting
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

endmodule

bind modbus_rtu_frame_engine_unit mrfe_checker u_mrfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
